// File: design/trdma_pkg.sv
// ----------------------------------------------------------------------------
// trdma_pkg: shared types and constants for the transmit ring DMA scheduler
// Field widths, event and status codes, and the result record.
// ----------------------------------------------------------------------------
package trdma_pkg;

  // Fixed field widths of the item channels
  localparam int FUNC_W    = 2;
  localparam int LEN_W     = 13;
  localparam int OUT_IDX_W = 12;
  localparam int STATUS_W  = 3;

  // Default ring size in bytes
  localparam int BUFFER_LEN_DEFAULT = 4096;

  // Event codes carried in func
  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_DONE  = 2'd1,
    FN_ERROR = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_TOO_LONG   = 3'd1,
    ST_OVF_WRAP   = 3'd2,
    ST_OVF_NOWRAP = 3'd3,
    ST_XFER_ERR   = 3'd4
  } status_t;

  // One result item
  typedef struct packed {
    status_t              status;
    logic [OUT_IDX_W-1:0] copy_index;
    logic                 start_valid;
    logic [OUT_IDX_W-1:0] start_index;
    logic [LEN_W-1:0]     chunk_len;
  } result_t;

endpackage

// File: design/trdma_if.sv
// ----------------------------------------------------------------------------
// trdma_if: valid/ready channels of the transmit ring DMA scheduler
// Request channel carries events, response channel carries results.
// ----------------------------------------------------------------------------
interface trdma_req_if;
  logic                           valid;
  logic                           ready;
  logic [trdma_pkg::FUNC_W-1:0]   func;
  logic [trdma_pkg::LEN_W-1:0]    length;

  modport source (output valid, output func, output length, input ready);
  modport sink   (input valid, input func, input length, output ready);
endinterface

interface trdma_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [trdma_pkg::STATUS_W-1:0]    status;
  logic [trdma_pkg::OUT_IDX_W-1:0]   copy_index;
  logic                              start_valid;
  logic [trdma_pkg::OUT_IDX_W-1:0]   start_index;
  logic [trdma_pkg::LEN_W-1:0]       chunk_len;

  modport source (output valid, output status, output copy_index, output start_valid,
                  output start_index, output chunk_len, input ready);
  modport sink   (input valid, input status, input copy_index, input start_valid,
                  input start_index, input chunk_len, output ready);
endinterface

// File: design/trdma_ptrs.sv
// ----------------------------------------------------------------------------
// trdma_ptrs: ring pointer state and per-event evaluation
// Holds write/read indexes, chunk in flight and busy; computes one result
// per event and commits the next state when step is high.
// ----------------------------------------------------------------------------
module trdma_ptrs #(
  parameter int BUFFER_LEN = trdma_pkg::BUFFER_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [trdma_pkg::FUNC_W-1:0] func,
  input  logic [trdma_pkg::LEN_W-1:0]  length,
  output trdma_pkg::result_t           result
);
  import trdma_pkg::*;

  localparam int IDX_W = $clog2(BUFFER_LEN);
  localparam int CNT_W = IDX_W + 1;
  localparam int SUM_W = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;
  localparam logic [SUM_W-1:0] BL_S = SUM_W'(BUFFER_LEN);

  // State
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] chunk_in_flight, chunk_in_flight_next;
  logic             busy, busy_next;

  // Widened operands
  logic [SUM_W-1:0] wr_s, rd_s, n_s, wsum, rsum;
  logic             too_long, ovf_wrap, ovf_nowrap;
  logic [IDX_W-1:0] wr_adv, rd_adv;

  // Chunk computation, shared between write and completion
  logic [IDX_W-1:0] c_rd, c_wr;
  logic [CNT_W-1:0] c_len;

  assign wr_s = SUM_W'(write_index);
  assign rd_s = SUM_W'(read_index);
  assign n_s  = SUM_W'(length);

  // Write side checks and wrapped advance
  assign wsum       = wr_s + n_s;
  assign too_long   = n_s >= BL_S;
  assign ovf_wrap   = (wr_s >= rd_s) && (wsum >= BL_S) && ((wsum - BL_S) >= rd_s);
  assign ovf_nowrap = (wr_s < rd_s) && (wsum >= rd_s);
  assign wr_adv     = (wsum >= BL_S) ? IDX_W'(wsum - BL_S) : IDX_W'(wsum);

  // Completion advance of the read index
  assign rsum   = rd_s + SUM_W'(chunk_in_flight);
  assign rd_adv = (rsum >= BL_S) ? IDX_W'(rsum - BL_S) : IDX_W'(rsum);

  // Chunk runs to the write index or to the buffer end
  assign c_rd  = (func == FN_DONE) ? rd_adv : read_index;
  assign c_wr  = (func == FN_DONE) ? write_index : wr_adv;
  assign c_len = (c_rd < c_wr) ? (CNT_W'(c_wr) - CNT_W'(c_rd))
                               : (CNT_W'(BUFFER_LEN) - CNT_W'(c_rd));

  // Event evaluation
  always_comb begin
    write_index_next     = write_index;
    read_index_next      = read_index;
    chunk_in_flight_next = chunk_in_flight;
    busy_next            = busy;
    result               = '0;
    result.status        = ST_OK;
    case (func)
      FN_WRITE: begin
        if (too_long) begin
          result.status = ST_TOO_LONG;
        end else if (ovf_wrap) begin
          result.status = ST_OVF_WRAP;
        end else if (ovf_nowrap) begin
          result.status = ST_OVF_NOWRAP;
        end else begin
          result.copy_index = OUT_IDX_W'(write_index);
          if (length != '0) begin
            write_index_next = wr_adv;
            if (!busy) begin
              chunk_in_flight_next = c_len;
              busy_next            = 1'b1;
              result.start_valid   = 1'b1;
              result.start_index   = OUT_IDX_W'(c_rd);
              result.chunk_len     = LEN_W'(c_len);
            end
          end
        end
      end
      FN_DONE: begin
        if (busy) begin
          busy_next            = 1'b0;
          read_index_next      = rd_adv;
          chunk_in_flight_next = '0;
          if (write_index != rd_adv) begin
            chunk_in_flight_next = c_len;
            busy_next            = 1'b1;
            result.start_valid   = 1'b1;
            result.start_index   = OUT_IDX_W'(c_rd);
            result.chunk_len     = LEN_W'(c_len);
          end
        end
      end
      FN_ERROR: begin
        result.status        = ST_XFER_ERR;
        busy_next            = 1'b0;
        chunk_in_flight_next = '0;
      end
      default: begin
        // unused code: no effect
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index     <= '0;
      read_index      <= '0;
      chunk_in_flight <= '0;
      busy            <= 1'b0;
    end else if (step) begin
      write_index     <= write_index_next;
      read_index      <= read_index_next;
      chunk_in_flight <= chunk_in_flight_next;
      busy            <= busy_next;
    end
  end

endmodule

// File: design/tx_ring_dma_scheduler_unit.sv
// An accepted event item passes through the input register, then the result
// register, which presents its result item.
// Throughput: one event item per cycle unless the result channel stalls; the
// pointer update is one compare and add stage between the input register and
// the result register. A stalled result holds in the result register while one
// more item waits in the input register.
// Reset (rst, synchronous) clears the indexes, chunk count, busy and valid flags.
// ----------------------------------------------------------------------------
// tx_ring_dma_scheduler_unit: transmit ring buffer DMA chunk scheduler
// Reserves ring space for writes and starts DMA chunks on completions.
// ----------------------------------------------------------------------------
module tx_ring_dma_scheduler_unit #(
  parameter int BUFFER_LEN = trdma_pkg::BUFFER_LEN_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  trdma_req_if.sink req,
  trdma_rsp_if.source rsp
);
  import trdma_pkg::*;

  // Input register
  logic              s1_valid;
  logic [FUNC_W-1:0] s1_func;
  logic [LEN_W-1:0]  s1_length;

  // Result register
  logic    out_valid;
  result_t out_res;
  result_t eval_res;

  logic advance;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  trdma_ptrs #(
    .BUFFER_LEN(BUFFER_LEN)
  ) u_ptrs (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .func   (s1_func),
    .length (s1_length),
    .result (eval_res)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_func   <= req.func;
      s1_length <= req.length;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= eval_res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_res.status;
  assign rsp.copy_index  = out_res.copy_index;
  assign rsp.start_valid = out_res.start_valid;
  assign rsp.start_index = out_res.start_index;
  assign rsp.chunk_len   = out_res.chunk_len;

  // Checks
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !rsp.ready) |-> !req.ready)
    else $error("input accepted while both stages are full");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("pending item dropped from input register");

  a_no_start_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |-> !rsp.start_valid)
    else $error("chunk started on a failed item");

endmodule

// File: sim/tx_ring_dma_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_ring_dma_scheduler_unit_tb: self-checking bench for the ring DMA scheduler
// Drives write, completion, error and unused events through the request channel with
// random gaps. A scoreboard keeps its own copy of the ring pointers and checks
// every response item field by field. The receiver stalls at random.
// ----------------------------------------------------------------------------
module tx_ring_dma_scheduler_unit_tb;
  import trdma_pkg::*;

  localparam int RING_BYTES   = BUFFER_LEN_DEFAULT;
  localparam int TARGET_ITEMS = 1450;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 60;
  localparam int IDLE_PCT     = 33;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  // Ring pointer predictor and expected response store
  class ring_scoreboard;
    logic [OUT_IDX_W-1:0] wr_idx;
    logic [OUT_IDX_W-1:0] rd_idx;
    logic [LEN_W-1:0]     in_flight;
    logic                 busy;
    result_t              expected_q[$];
    int n_events;
    int n_ignored;
    int n_checked;
    int n_errors;
    int n_starts;
    int n_status[5];

    function new();
      wr_idx    = '0;
      rd_idx    = '0;
      in_flight = '0;
      busy      = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Next contiguous chunk runs to the write index or the ring end
    function void start_chunk(inout result_t r);
      int len;
      if (rd_idx < wr_idx) len = wr_idx - rd_idx;
      else len = RING_BYTES - rd_idx;
      in_flight     = LEN_W'(len);
      busy          = 1'b1;
      r.start_valid = 1'b1;
      r.start_index = rd_idx;
      r.chunk_len   = LEN_W'(len);
    endfunction

    // Accepted event: update pointers, queue the expected response
    function void note_event(input logic [FUNC_W-1:0] f, input logic [LEN_W-1:0] n);
      result_t r;
      int wr;
      int rd;
      int sum;
      r   = '0;
      wr  = wr_idx;
      rd  = rd_idx;
      sum = wr + n;
      n_events++;
      case (f)
        FN_WRITE: begin
          if (n >= RING_BYTES) r.status = ST_TOO_LONG;
          else if (wr >= rd && sum >= RING_BYTES && sum - RING_BYTES >= rd)
            r.status = ST_OVF_WRAP;
          else if (wr < rd && sum >= rd) r.status = ST_OVF_NOWRAP;
          else begin
            r.copy_index = wr_idx;
            if (n != 0) begin
              wr_idx = OUT_IDX_W'(sum % RING_BYTES);
              if (!busy) start_chunk(r);
            end
          end
        end
        FN_DONE: begin
          if (!busy) n_ignored++;
          else begin
            busy      = 1'b0;
            rd_idx    = OUT_IDX_W'((rd + in_flight) % RING_BYTES);
            in_flight = '0;
            if (wr_idx != rd_idx) start_chunk(r);
          end
        end
        FN_ERROR: begin
          r.status  = ST_XFER_ERR;
          busy      = 1'b0;
          in_flight = '0;
        end
        default: n_ignored++;
      endcase
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        n_errors++;
      end
    endfunction

    // Response item: compare against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected response item: status %0d copy_index %0d", got.status,
               got.copy_index);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      n_status[want.status]++;
      if (want.start_valid) n_starts++;
      cmp_field("status", LEN_W'(want.status), LEN_W'(got.status));
      cmp_field("copy_index", LEN_W'(want.copy_index), LEN_W'(got.copy_index));
      cmp_field("start_valid", LEN_W'(want.start_valid), LEN_W'(got.start_valid));
      cmp_field("start_index", LEN_W'(want.start_index), LEN_W'(got.start_index));
      cmp_field("chunk_len", want.chunk_len, got.chunk_len);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles = 0;
  int   sent;

  trdma_req_if req ();
  trdma_rsp_if rsp ();

  ring_scoreboard sb = new();

  tx_ring_dma_scheduler_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Clock and run limit
  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) sb.note_event(req.func, req.length);
      if (rsp.valid && rsp.ready)
        sb.check_result({rsp.status, rsp.copy_index, rsp.start_valid, rsp.start_index,
                         rsp.chunk_len});
    end
  end

  // Receiver: random stalls, one long hold, one stall-free stretch
  initial begin : receiver
    bit held;
    bit calm;
    held = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      calm = sb.n_checked >= 700 && sb.n_checked < 900;
      if (!rst && !held && sb.n_checked >= 300) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one event item; called and returns at a falling edge
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [LEN_W-1:0] n);
    bit calm;
    calm = sent >= 700 && sent < 900;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid  <= 1'b1;
    req.func   <= f;
    req.length <= n;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Stop offering until every expected response has arrived
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin : sender
    logic [FUNC_W-1:0] f;
    logic [LEN_W-1:0]  n;
    int  roll;
    int  kind;
    bit  filling;
    sent       = 0;
    filling    = 1'b1;
    rst        = 1'b1;
    req.valid  = 1'b0;
    req.func   = FN_WRITE;
    req.length = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle events, length extremes, full ring, both overflows, wrap
    send_item(FN_DONE, 13'd0);        // completion while idle
    send_item(FN_UNUSED, 13'd8191);   // unused code
    send_item(FN_ERROR, 13'd4096);    // error while idle
    send_item(FN_WRITE, 13'd0);       // zero length
    send_item(FN_WRITE, 13'd4096);    // too long
    send_item(FN_WRITE, 13'd8191);    // too long, all bits set
    send_item(FN_WRITE, 13'd4095);    // fills ring to one free byte
    send_item(FN_WRITE, 13'd1);       // overflow, write ahead of read
    send_item(FN_WRITE, 13'd0);       // zero length while busy
    send_item(FN_DONE, 13'd0);        // ring drained, no new chunk
    send_item(FN_DONE, 13'd0);        // idle again
    send_item(FN_WRITE, 13'd2);       // write wraps, chunk to ring end
    send_item(FN_WRITE, 13'd4094);    // overflow, write behind read
    send_item(FN_WRITE, 13'd4093);    // fills the wrapped ring
    send_item(FN_DONE, 13'd0);        // chunk from index zero
    send_item(FN_ERROR, 13'd0);       // abandon active chunk
    send_item(FN_DONE, 13'd0);        // completion after error ignored
    send_item(FN_WRITE, 13'd1);       // restart from read index
    send_item(FN_DONE, 13'd0);
    send_item(FN_UNUSED, 13'd0);

    // Random: alternating fill and drain phases
    while (sent < TARGET_ITEMS) begin
      if ($urandom_range(49) == 0) filling = !filling;
      if (sent == 1000) wait_drained();
      roll = $urandom_range(99);
      if (roll < 2) begin
        f = FN_UNUSED;
        n = LEN_W'($urandom);
      end else if (roll < 5) begin
        f = FN_ERROR;
        n = LEN_W'($urandom);
      end else if (roll < (filling ? 15 : 55)) begin
        f = FN_DONE;
        n = LEN_W'($urandom);
      end else begin
        f = FN_WRITE;
        kind = $urandom_range(99);
        if (kind < 6) n = '0;
        else if (kind < 78) n = LEN_W'($urandom_range(400, 1));
        else if (kind < 90) n = LEN_W'($urandom_range(4095, 401));
        else if (kind < 94) n = LEN_W'(4095 - $urandom_range(2));
        else n = LEN_W'($urandom_range(8191, 4096));
      end
      send_item(f, n);
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d events (%0d ignored), %0d responses: %0d ok, %0d too long,",
             sb.n_events, sb.n_ignored, sb.n_checked, sb.n_status[ST_OK],
             sb.n_status[ST_TOO_LONG]);
    $display("  %0d wrap overflows, %0d overflows, %0d transfer errors, %0d chunk starts",
             sb.n_status[ST_OVF_WRAP], sb.n_status[ST_OVF_NOWRAP],
             sb.n_status[ST_XFER_ERR], sb.n_starts);
    if (sb.n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
